// File: rtl/rc4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher package
// Shared constants, sequencer state type and the table memory request struct.
// ----------------------------------------------------------------------------
package rc4_pkg;

  // Default number of key bytes cycled over the schedule
  localparam int unsigned KEY_BYTES = 4;
  // Bytes held by the key register
  localparam int unsigned KEY_REG_BYTES = 4;
  // Permutation table depth
  localparam int unsigned TABLE_SIZE = 256;
  // Last table index
  localparam logic [7:0] IDX_LAST = 8'(TABLE_SIZE - 1);

  typedef logic [7:0] rc4_byte_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_RD_I,
    ST_KSA_RD_J,
    ST_KSA_WR_I,
    ST_KSA_WR_J,
    ST_GEN_RD_I,
    ST_GEN_RD_J,
    ST_GEN_WR_I,
    ST_GEN_WR_J,
    ST_GEN_RD_K,
    ST_GEN_KEY,
    ST_DONE
  } rc4_state_e;

  // One write port and one read port on the permutation table
  typedef struct packed {
    logic      we;
    rc4_byte_t waddr;
    rc4_byte_t wdata;
    rc4_byte_t raddr;
  } rc4_mem_req_t;

endpackage

// File: rtl/rc4_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 permutation table
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module rc4_perm_ram (
  input  logic                 clk_i,
  input  rc4_pkg::rc4_mem_req_t req_i,
  output rc4_pkg::rc4_byte_t   rdata_o
);

  rc4_pkg::rc4_byte_t mem [rc4_pkg::TABLE_SIZE];
  rc4_pkg::rc4_byte_t rdata_q;

  // Write one entry and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rc4_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 sequencer
// Steps the key schedule and keystream generation over the table memory,
// sharing one 8-bit three-operand adder for the j and keystream-index sums.
// ----------------------------------------------------------------------------
module rc4_ctrl #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  rc4_pkg::rc4_byte_t    plain_byte_i,
  input  logic [31:0]           key_i,
  input  logic                  out_free_i,
  output rc4_pkg::rc4_mem_req_t mem_req_o,
  input  rc4_pkg::rc4_byte_t    mem_rdata_i,
  output logic                  res_valid_o,
  output rc4_pkg::rc4_byte_t    res_byte_o,
  output logic                  keyed_o
);

  localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);

  rc4_pkg::rc4_state_e state_q, state_d;
  rc4_pkg::rc4_byte_t  i_q, i_d;
  rc4_pkg::rc4_byte_t  j_q, j_d;
  rc4_pkg::rc4_byte_t  si_q, si_d;
  rc4_pkg::rc4_byte_t  sj_q, sj_d;
  rc4_pkg::rc4_byte_t  ks_q, ks_d;
  rc4_pkg::rc4_byte_t  data_q, data_d;
  logic                keyed_q, keyed_d;
  logic [KIDX_W-1:0]   kidx_q, kidx_d;

  rc4_pkg::rc4_byte_t  add_a, add_b, add_c, add_sum;
  rc4_pkg::rc4_byte_t  key_bytes [8];
  rc4_pkg::rc4_byte_t  key_sel;
  logic [2:0]          kidx_sel;
  logic                start;

  // Shared index adder
  assign add_sum = add_a + add_b + add_c;

  // Key byte lanes; lanes past the register read as zero
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      key_bytes[k] = '0;
    end
    key_bytes[0] = key_i[7:0];
    key_bytes[1] = key_i[15:8];
    key_bytes[2] = key_i[23:16];
    key_bytes[3] = key_i[31:24];
  end

  assign kidx_sel = 3'(kidx_q);
  assign key_sel  = key_bytes[kidx_sel];
  assign start    = mode_i | ~keyed_q;
  assign keyed_o  = keyed_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = start ? rc4_pkg::ST_FILL : rc4_pkg::ST_GEN_RD_I;
        end
      end
      rc4_pkg::ST_FILL: begin
        if (i_q == rc4_pkg::IDX_LAST) begin
          state_d = rc4_pkg::ST_KSA_RD_I;
        end
      end
      rc4_pkg::ST_KSA_RD_I: state_d = rc4_pkg::ST_KSA_RD_J;
      rc4_pkg::ST_KSA_RD_J: state_d = rc4_pkg::ST_KSA_WR_I;
      rc4_pkg::ST_KSA_WR_I: state_d = rc4_pkg::ST_KSA_WR_J;
      rc4_pkg::ST_KSA_WR_J: begin
        state_d = (i_q == rc4_pkg::IDX_LAST) ? rc4_pkg::ST_GEN_RD_I : rc4_pkg::ST_KSA_RD_I;
      end
      rc4_pkg::ST_GEN_RD_I: state_d = rc4_pkg::ST_GEN_RD_J;
      rc4_pkg::ST_GEN_RD_J: state_d = rc4_pkg::ST_GEN_WR_I;
      rc4_pkg::ST_GEN_WR_I: state_d = rc4_pkg::ST_GEN_WR_J;
      rc4_pkg::ST_GEN_WR_J: state_d = rc4_pkg::ST_GEN_RD_K;
      rc4_pkg::ST_GEN_RD_K: state_d = rc4_pkg::ST_GEN_KEY;
      rc4_pkg::ST_GEN_KEY: begin
        state_d = out_free_i ? rc4_pkg::ST_IDLE : rc4_pkg::ST_DONE;
      end
      rc4_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = rc4_pkg::ST_IDLE;
        end
      end
      default: state_d = rc4_pkg::ST_IDLE;
    endcase
  end

  // Memory requests, adder operands and handshake outputs
  always_comb begin
    mem_req_o       = '0;
    mem_req_o.raddr = i_q;
    mem_req_o.waddr = i_q;
    add_a           = j_q;
    add_b           = mem_rdata_i;
    add_c           = '0;
    in_stall_o      = (state_q != rc4_pkg::ST_IDLE);
    res_valid_o     = 1'b0;
    res_byte_o      = data_q ^ mem_rdata_i;
    case (state_q)
      rc4_pkg::ST_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = i_q;
      end
      rc4_pkg::ST_KSA_RD_J: begin
        add_c           = key_sel;
        mem_req_o.raddr = add_sum;
      end
      rc4_pkg::ST_KSA_WR_I, rc4_pkg::ST_GEN_WR_I: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = mem_rdata_i;
      end
      rc4_pkg::ST_KSA_WR_J, rc4_pkg::ST_GEN_WR_J: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = si_q;
      end
      rc4_pkg::ST_GEN_RD_I: begin
        mem_req_o.raddr = i_q + 8'd1;
      end
      rc4_pkg::ST_GEN_RD_J: begin
        mem_req_o.raddr = add_sum;
      end
      rc4_pkg::ST_GEN_RD_K: begin
        add_a           = si_q;
        add_b           = sj_q;
        mem_req_o.raddr = add_sum;
      end
      rc4_pkg::ST_GEN_KEY: begin
        res_valid_o = out_free_i;
      end
      rc4_pkg::ST_DONE: begin
        res_valid_o = out_free_i;
        res_byte_o  = data_q ^ ks_q;
      end
      default: begin
      end
    endcase
  end

  // Index, key lane and captured table values
  always_comb begin
    i_d     = i_q;
    j_d     = j_q;
    si_d    = si_q;
    sj_d    = sj_q;
    ks_d    = ks_q;
    data_d  = data_q;
    keyed_d = keyed_q;
    kidx_d  = kidx_q;
    case (state_q)
      rc4_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          data_d = plain_byte_i;
          if (start) begin
            i_d    = '0;
            j_d    = '0;
            kidx_d = '0;
          end
        end
      end
      rc4_pkg::ST_FILL: begin
        i_d = i_q + 8'd1;
      end
      rc4_pkg::ST_KSA_RD_J, rc4_pkg::ST_GEN_RD_J: begin
        si_d = mem_rdata_i;
        j_d  = add_sum;
      end
      rc4_pkg::ST_KSA_WR_J: begin
        i_d    = i_q + 8'd1;
        kidx_d = (kidx_q == KIDX_LAST) ? '0 : kidx_q + KIDX_W'(1);
        if (i_q == rc4_pkg::IDX_LAST) begin
          j_d     = '0;
          keyed_d = 1'b1;
        end
      end
      rc4_pkg::ST_GEN_RD_I: begin
        i_d = i_q + 8'd1;
      end
      rc4_pkg::ST_GEN_WR_I: begin
        sj_d = mem_rdata_i;
      end
      rc4_pkg::ST_GEN_KEY: begin
        ks_d = mem_rdata_i;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rc4_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      keyed_q <= 1'b0;
      kidx_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      keyed_q <= keyed_d;
      kidx_q  <= kidx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    ks_q   <= ks_d;
    data_q <= data_d;
  end

endmodule

// File: rtl/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Encrypts or decrypts one byte per item with the RC4 keystream; a start item
// reruns the key schedule from the key register.
// ----------------------------------------------------------------------------
// Each accepted item returns one result byte; the block takes no new item
// until the current one is through. A continuing item steps through GEN_RD_I,
// GEN_RD_J, GEN_WR_I, GEN_WR_J, GEN_RD_K and GEN_KEY, as the permutation table
// (one read port, one write port) is read three times and written twice per
// keystream byte. An item with mode set (and any item before the first
// schedule) first fills the table, then runs KSA_RD_I, KSA_RD_J, KSA_WR_I and
// KSA_WR_J for each entry. The result waits in an output register, so the next
// item is accepted while it is still stalled.
module rc4_stream_cipher #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Key register write
  input  logic        cipher_key_we_i,
  input  logic [31:0] cipher_key_i,
  // Input item
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [7:0]  plain_byte_i,
  // Result item
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  cipher_byte_o
);

  logic [31:0]           key_q;
  logic                  out_valid_q;
  rc4_pkg::rc4_byte_t    cipher_byte_q;
  logic                  out_free;
  logic                  res_valid;
  rc4_pkg::rc4_byte_t    res_byte;
  logic                  keyed;
  rc4_pkg::rc4_mem_req_t mem_req;
  rc4_pkg::rc4_byte_t    mem_rdata;

  assign out_free = ~out_valid_q | ~out_stall_i;

  // Key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cipher_key_we_i) begin
      key_q <= cipher_key_i;
    end
  end

  rc4_ctrl #(
    .KEY_BYTES (KEY_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .plain_byte_i (plain_byte_i),
    .key_i        (key_q),
    .out_free_i   (out_free),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_valid_o  (res_valid),
    .res_byte_o   (res_byte),
    .keyed_o      (keyed)
  );

  rc4_perm_ram u_perm_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output valid: load on a new result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output byte: hold until the next result
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      cipher_byte_q <= res_byte;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = cipher_byte_q;

  // The block is busy in the cycle after it takes an item
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous item still in flight");

  // A result never overwrites an undelivered one
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled output item");

  // A produced result shows up at the output
  a_result_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_o)
    else $error("result lost before output register");

  // Once scheduled, the table stays keyed
  a_keyed_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    keyed |=> keyed)
    else $error("keyed flag dropped");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Streams data bytes through the cipher, with message starts, key changes
// between messages and random idling on both sides, and checks every result
// byte against a keystream predictor kept inside the testbench.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic        MODE_CONTINUE = 1'b0;
  localparam logic        MODE_REKEY    = 1'b1;
  localparam int unsigned RANDOM_ITEMS  = 600;
  localparam int unsigned MAX_IDLE      = 6;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned STUCK_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct {
    logic               mode;
    rc4_pkg::rc4_byte_t data;
  } cipher_item_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cipher_key_we_i = 1'b0;
  logic [31:0] cipher_key_i    = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic        mode_i          = 1'b0;
  logic [7:0]  plain_byte_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  cipher_byte_o;

  // Stimulus and expectation stores
  cipher_item_t       pending_items[$];
  rc4_pkg::rc4_byte_t expected_bytes[$];

  // Keystream predictor state
  rc4_pkg::rc4_byte_t perm_model[rc4_pkg::TABLE_SIZE];
  rc4_pkg::rc4_byte_t idx_i_model;
  rc4_pkg::rc4_byte_t idx_j_model;
  logic               keyed_model = 1'b0;
  logic [31:0]        key_model   = '0;

  // Idling controls, set per phase
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned holds_req  = 0;
  int unsigned holds_seen = 0;
  int unsigned hold_left  = 0;
  int unsigned tx_wait    = 0;
  int unsigned rx_wait    = 0;

  int unsigned mismatches = 0;
  int unsigned stuck_cnt  = 0;

  rc4_stream_cipher u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cipher_key_we_i(cipher_key_we_i),
    .cipher_key_i   (cipher_key_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .plain_byte_i   (plain_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cipher_byte_o  (cipher_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the keystream by one byte, rerunning the key schedule first on a
  // message start or before the very first schedule
  function automatic rc4_pkg::rc4_byte_t predict_cipher(input logic start,
                                                        input rc4_pkg::rc4_byte_t data);
    rc4_pkg::rc4_byte_t acc;
    rc4_pkg::rc4_byte_t tmp;
    rc4_pkg::rc4_byte_t kb;
    rc4_pkg::rc4_byte_t sel;
    int unsigned        b;
    if (start || !keyed_model) begin
      for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
        perm_model[n] = 8'(n);
      end
      acc = '0;
      for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
        b   = n % rc4_pkg::KEY_BYTES;
        // key bytes past the register read as zero
        kb  = (b < rc4_pkg::KEY_REG_BYTES) ? key_model[8*b +: 8] : 8'h00;
        acc = acc + perm_model[n] + kb;
        tmp = perm_model[n];
        perm_model[n] = perm_model[acc];
        perm_model[acc] = tmp;
      end
      idx_i_model = '0;
      idx_j_model = '0;
      keyed_model = 1'b1;
    end
    idx_i_model = idx_i_model + 8'd1;
    idx_j_model = idx_j_model + perm_model[idx_i_model];
    tmp = perm_model[idx_i_model];
    perm_model[idx_i_model] = perm_model[idx_j_model];
    perm_model[idx_j_model] = tmp;
    sel = perm_model[idx_i_model] + perm_model[idx_j_model];
    return data ^ perm_model[sel];
  endfunction

  // Driver: predict on acceptance, then offer the next item after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    cipher_item_t nxt;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      mode_i       <= MODE_CONTINUE;
      plain_byte_i <= '0;
      tx_wait      <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      expected_bytes.push_back(predict_cipher(mode_i, plain_byte_i));
      gap = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap == 0 && pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        mode_i       <= nxt.mode;
        plain_byte_i <= nxt.data;
      end else begin
        in_valid_i <= 1'b0;
        tx_wait    <= gap;
      end
    end else if (!in_valid_i) begin
      if (tx_wait != 0) begin
        tx_wait <= tx_wait - 1;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_valid_i   <= 1'b1;
        mode_i       <= nxt.mode;
        plain_byte_i <= nxt.data;
      end
    end
  end

  // Monitor: check each result, then draw the stall before the next one
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned        wait_n;
    rc4_pkg::rc4_byte_t exp_byte;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait     <= 0;
      hold_left   <= 0;
      holds_seen  <= 0;
    end else begin
      wait_n = rx_wait;
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result cipher_byte=%02h", $realtime, cipher_byte_o);
        end else begin
          exp_byte = expected_bytes.pop_front();
          if (cipher_byte_o !== exp_byte) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: cipher_byte mismatch: expected %02h, got %02h",
                       $realtime, exp_byte, cipher_byte_o);
          end
        end
        wait_n = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (wait_n != 0) begin
        wait_n--;
      end
      // long hold-off so the block backs up into its input
      if (holds_req != holds_seen) begin
        hold_left  <= LONG_HOLD;
        holds_seen <= holds_req;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end
      rx_wait     <= wait_n;
      out_stall_i <= (wait_n != 0) || (hold_left > 1) || (holds_req != holds_seen);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  task automatic push_item(input logic mode, input rc4_pkg::rc4_byte_t data);
    cipher_item_t it;
    it.mode = mode;
    it.data = data;
    pending_items.push_back(it);
  endtask

  // Hold until every item is taken and every result has come back
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_key(input logic [31:0] key);
    @(posedge clk_i);
    cipher_key_we_i <= 1'b1;
    cipher_key_i    <= key;
    @(posedge clk_i);
    cipher_key_we_i <= 1'b0;
    @(negedge clk_i);
    key_model = key;
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned phase_no;
    int unsigned len;
    int unsigned half;
    logic [31:0] key;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // No schedule yet: a continuing byte still keys the table from the reset key
    @(negedge clk_i);
    push_item(MODE_CONTINUE, 8'h00);
    push_item(MODE_CONTINUE, 8'hFF);
    push_item(MODE_REKEY, 8'h5A);
    wait_idle();

    // All-ones key, back-to-back starts
    write_key(32'hFFFF_FFFF);
    push_item(MODE_REKEY, 8'hFF);
    push_item(MODE_CONTINUE, 8'h00);
    push_item(MODE_CONTINUE, 8'h80);
    push_item(MODE_CONTINUE, 8'h01);
    push_item(MODE_REKEY, 8'h7F);
    push_item(MODE_REKEY, 8'hFE);
    wait_idle();

    // Key change mid-stream takes effect only at the next start
    write_key(32'h0123_4567);
    push_item(MODE_CONTINUE, 8'h00);
    push_item(MODE_CONTINUE, 8'hFF);
    push_item(MODE_CONTINUE, 8'h55);
    push_item(MODE_REKEY, 8'hAA);
    push_item(MODE_CONTINUE, 8'h33);
    wait_idle();

    write_key(32'h0000_0000);
    push_item(MODE_REKEY, 8'h00);
    push_item(MODE_CONTINUE, 8'hFF);
    push_item(MODE_CONTINUE, 8'h0F);
    push_item(MODE_CONTINUE, 8'hF0);
    wait_idle();

    write_key(32'h8000_0001);
    push_item(MODE_REKEY, 8'hC3);
    push_item(MODE_CONTINUE, 8'h3C);
    wait_idle();

    // Random phases: mostly well-formed messages, some bare continuations
    // and a little noise with a random mode bit
    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       key = 32'h0000_0000;
        1:       key = 32'hFFFF_FFFF;
        default: key = $urandom;
      endcase
      write_key(key);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 6)) begin
              push_item(1'($urandom_range(0, 1)), 8'($urandom));
              random_sent++;
            end
          end
          1, 2: begin
            repeat ($urandom_range(1, 20)) begin
              push_item(MODE_CONTINUE, 8'($urandom));
              random_sent++;
            end
          end
          default: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300)
                                              : $urandom_range(1, 25);
            push_item(MODE_REKEY, 8'($urandom));
            random_sent++;
            repeat (len) begin
              push_item(MODE_CONTINUE, 8'($urandom));
              random_sent++;
            end
          end
        endcase
      end
      // every third phase, stall the receiver while the sender keeps going
      if (phase_no % 3 == 1) begin
        half = pending_items.size() / 2;
        while (pending_items.size() > half) @(negedge clk_i);
        holds_req++;
      end
      phase_no++;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/rc4_pkg.sv
rtl/rc4_perm_ram.sv
rtl/rc4_ctrl.sv
rtl/rc4_stream_cipher.sv
tb/testbench.sv
